### hw/rtl/mpfa_pkg.sv
// Package for the prime field ALU: field constants, operand widths, op codes.
// No dependencies; used by the interfaces, the multiplier and the top level.
`timescale 1ns / 1ps
package mpfa_pkg;

  localparam int LIMB_W = 64;
  localparam int HIGH_W = 31;
  localparam int OPER_W = 2 * LIMB_W + HIGH_W;   // 159-bit operand
  localparam int WORD_W = 3 * LIMB_W;            // 192-bit working value
  localparam int DIG_W  = 32;
  localparam int NDIG   = 5;                     // 32-bit digits per operand
  localparam int PROD_W = 2 * NDIG * DIG_W;      // 320-bit full product
  localparam int ROW_W  = 2 * DIG_W + (NDIG - 1) * DIG_W;

  // p = 2^158 + 192*2^30 + 1
  localparam logic [WORD_W-1:0] P_MOD =
    WORD_W'((192'd1 << 158) + (192'd192 << 30) + 192'd1);

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

endpackage

### hw/rtl/mpfa_if.sv
// Valid/ready channel interfaces for operand items and result items.
// Depends on mpfa_pkg for widths.
`timescale 1ns / 1ps
interface mpfa_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [mpfa_pkg::LIMB_W-1:0]  x_low;
  logic [mpfa_pkg::LIMB_W-1:0]  x_mid;
  logic [mpfa_pkg::HIGH_W-1:0]  x_high;
  logic [mpfa_pkg::LIMB_W-1:0]  y_low;
  logic [mpfa_pkg::LIMB_W-1:0]  y_mid;
  logic [mpfa_pkg::HIGH_W-1:0]  y_high;

  modport source (output valid, func, x_low, x_mid, x_high, y_low, y_mid, y_high,
                  input ready);
  modport sink   (input valid, func, x_low, x_mid, x_high, y_low, y_mid, y_high,
                  output ready);
endinterface

interface mpfa_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpfa_pkg::LIMB_W-1:0]  z_low;
  logic [mpfa_pkg::LIMB_W-1:0]  z_mid;
  logic [mpfa_pkg::HIGH_W-1:0]  z_high;

  modport source (output valid, z_low, z_mid, z_high, input ready);
  modport sink   (input valid, z_low, z_mid, z_high, output ready);
endinterface

### hw/rtl/mpfa_mont_mul.sv
// Six-stage Montgomery product x*y/2^192 (before the final subtraction of p).
// Stages: digit products, row sums, full product, three word reductions.
// Depends on mpfa_pkg.
`timescale 1ns / 1ps
module mpfa_mont_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic [mpfa_pkg::OPER_W-1:0]    x,
  input  logic [mpfa_pkg::OPER_W-1:0]    y,
  output logic [mpfa_pkg::WORD_W-1:0]    prod
);
  import mpfa_pkg::*;

  localparam int DPAD = NDIG * DIG_W;

  logic [DPAD-1:0]       xp, yp;
  logic [2*DIG_W-1:0]    pp_r [NDIG][NDIG];
  logic [ROW_W-1:0]      row_nxt [NDIG];
  logic [ROW_W-1:0]      row_r [NDIG];
  logic [PROD_W-1:0]     t_nxt, t_r;
  logic [PROD_W-1:0]     red_r [3];
  logic [PROD_W-1:0]     red_nxt [3];
  logic [PROD_W-1:0]     red_in [3];

  assign xp = DPAD'(x);
  assign yp = DPAD'(y);

  // stage 1: 25 digit products, 32x32 each
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NDIG; i++) begin
        for (int j = 0; j < NDIG; j++) begin
          pp_r[i][j] <= (2*DIG_W)'(xp[i*DIG_W +: DIG_W]) * (2*DIG_W)'(yp[j*DIG_W +: DIG_W]);
        end
      end
    end
  end

  // stage 2: one row per digit of y
  always_comb begin
    for (int j = 0; j < NDIG; j++) begin
      row_nxt[j] = '0;
      for (int i = 0; i < NDIG; i++) begin
        row_nxt[j] = row_nxt[j] + (ROW_W'(pp_r[i][j]) << (i * DIG_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) row_r <= row_nxt;
  end

  // stage 3: full product
  always_comb begin
    t_nxt = '0;
    for (int j = 0; j < NDIG; j++) begin
      t_nxt = t_nxt + (PROD_W'(row_r[j]) << (j * DIG_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) t_r <= t_nxt;
  end

  // stages 4..6: q = w * (3*2^36 - 1) mod 2^64, then (a + q*p) >> 64.
  // Both products are shift-adds since p = 2^158 + 3*2^36 + 1.
  assign red_in[0] = t_r;
  assign red_in[1] = red_r[0];
  assign red_in[2] = red_r[1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [LIMB_W-1:0] w, q;
      logic [PROD_W:0]   qm, s;
      w  = red_in[k][LIMB_W-1:0];
      q  = (w << 37) + (w << 36) - w;
      qm = (PROD_W+1)'(q) + ((PROD_W+1)'(q) << 36) + ((PROD_W+1)'(q) << 37)
         + ((PROD_W+1)'(q) << 158);
      s  = (PROD_W+1)'(red_in[k]) + qm;
      red_nxt[k] = PROD_W'(s >> LIMB_W);
    end
  end

  always_ff @(posedge clk) begin
    if (en) red_r <= red_nxt;
  end

  assign prod = red_r[2][WORD_W-1:0];

endmodule

### hw/rtl/montgomery_prime_field_alu.sv
// Prime field ALU top: modular add, subtract and Montgomery multiply mod p.
// One item per cycle sustained while the result register is not held.
// Seven-stage pipeline stalls as a whole when the result register is held.
// rst_n (synchronous, active low) clears all valid bits; no item is in flight after.
// Depends on mpfa_pkg, mpfa_if and mpfa_mont_mul.
`timescale 1ns / 1ps
module montgomery_prime_field_alu (
  input  logic       clk,
  input  logic       rst_n,
  mpfa_in_if.sink    in_ch,
  mpfa_out_if.source out_ch
);
  import mpfa_pkg::*;

  localparam int NST = 7;

  logic                en;
  logic [NST-1:0]      vld_r;
  logic [1:0]          func_r [NST-1];
  logic [OPER_W-1:0]   x_r, y_r, x_in, y_in;
  logic [WORD_W-1:0]   as_nxt;
  logic [WORD_W-1:0]   as_r [2:6];
  logic [WORD_W-1:0]   mul_prod;
  logic [WORD_W-1:0]   z_nxt, z_r;

  assign en          = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign x_in = {in_ch.x_high, in_ch.x_mid, in_ch.x_low};
  assign y_in = {in_ch.y_high, in_ch.y_mid, in_ch.y_low};

  function automatic logic [WORD_W-1:0] cond_sub(input logic [WORD_W-1:0] v);
    cond_sub = (v >= P_MOD) ? v - P_MOD : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r       <= x_in;
      y_r       <= y_in;
      func_r[0] <= in_ch.func;
      for (int k = 1; k < NST-1; k++) func_r[k] <= func_r[k-1];
      as_r[2]   <= as_nxt;
      for (int k = 3; k <= 6; k++) as_r[k] <= as_r[k-1];
      z_r       <= z_nxt;
    end
  end

  // add and subtract finish in stage 2 and ride along with the multiply
  always_comb begin
    logic [WORD_W:0] d;
    d = {1'b0, WORD_W'(x_r)} - {1'b0, WORD_W'(y_r)};
    unique case (func_t'(func_r[0]))
      FUNC_ADD: as_nxt = cond_sub(WORD_W'(x_r) + WORD_W'(y_r));
      FUNC_SUB: as_nxt = d[WORD_W] ? d[WORD_W-1:0] + P_MOD : d[WORD_W-1:0];
      default:  as_nxt = '0;
    endcase
  end

  mpfa_mont_mul u_mul (
    .clk  (clk),
    .en   (en),
    .x    (x_in),
    .y    (y_in),
    .prod (mul_prod)
  );

  always_comb begin
    unique case (func_t'(func_r[NST-2]))
      FUNC_ADD, FUNC_SUB: z_nxt = as_r[6];
      FUNC_MUL:           z_nxt = cond_sub(mul_prod);
      default:            z_nxt = '0;
    endcase
  end

  assign out_ch.valid  = vld_r[NST-1];
  assign out_ch.z_low  = z_r[LIMB_W-1:0];
  assign out_ch.z_mid  = z_r[2*LIMB_W-1:LIMB_W];
  assign out_ch.z_high = z_r[2*LIMB_W+HIGH_W-1:2*LIMB_W];

endmodule

### dv/tb_montgomery_prime_field_alu.sv
// Testbench for montgomery_prime_field_alu: directed and random add/sub/mul/nop items
// checked against a local field predictor. Depends on mpfa_pkg, mpfa_if and the RTL.
`timescale 1ns / 1ps
module tb_montgomery_prime_field_alu;
  import mpfa_pkg::*;

  localparam logic [63:0]  NEG_INV = (64'd192 << 30) - 64'd1;
  localparam logic [191:0] PRIME   = P_MOD;

  typedef struct {
    func_t             func;
    logic [OPER_W-1:0] x;
    logic [OPER_W-1:0] y;
  } field_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mpfa_in_if  in_ch ();
  mpfa_out_if out_ch ();

  montgomery_prime_field_alu uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  field_op_t         op_queue[$];
  logic [OPER_W-1:0] z_queue[$];
  int                mismatches = 0;
  bit                accepted = 0;
  int                src_gap = 0;
  int                snk_gap = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // 192-bit helpers; top limb wraps like a 64-bit word
  function automatic logic [191:0] fold_prime(input logic [191:0] v);
    return (v < PRIME) ? v : v - PRIME;
  endfunction

  function automatic logic [OPER_W-1:0] field_result(input field_op_t op);
    logic [191:0] a;
    logic [191:0] b;
    logic [191:0] z;
    logic [447:0] t;
    logic [63:0]  q;
    a = {33'd0, op.x};
    b = {33'd0, op.y};
    case (op.func)
      FUNC_ADD: z = fold_prime(a + b);
      FUNC_SUB: z = (a < b) ? (a - b + PRIME) : (a - b);
      FUNC_MUL: begin
        t = {256'd0, a} * {256'd0, b};
        for (int i = 0; i < 3; i++) begin
          q = t[64*i +: 64] * NEG_INV;
          t = t + (({384'd0, q} * {256'd0, PRIME}) << (64 * i));
        end
        z = fold_prime(t[383:192]);
      end
      default: z = '0;
    endcase
    return z[OPER_W-1:0];
  endfunction

  function automatic logic [OPER_W-1:0] rand_operand();
    logic [OPER_W-1:0] v;
    int sel;
    v = OPER_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = PRIME[OPER_W-1:0] - OPER_W'($urandom_range(1, 8));
      1: v = OPER_W'($urandom_range(0, 8));
      2: ;  // full 31-bit top limb, often non-canonical
      3: v = PRIME[OPER_W-1:0] + OPER_W'($urandom_range(0, 3));
      default: v[OPER_W-1 -: 2] = 2'b00;  // canonical range
    endcase
    return v;
  endfunction

  task automatic queue_op(input func_t f, input logic [OPER_W-1:0] x,
                          input logic [OPER_W-1:0] y);
    field_op_t op;
    op.func = f;
    op.x = x;
    op.y = y;
    op_queue = {op_queue, op};
  endtask

  // driver: changes on falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (accepted || !in_ch.valid) begin
        if (accepted) void'(op_queue.pop_front());
        accepted = 0;
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          if (op_queue.size() > 150 && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 2);
            in_ch.valid <= 1'b0;
          end else begin
            in_ch.valid  <= 1'b1;
            in_ch.func   <= op_queue[0].func;
            in_ch.x_low  <= op_queue[0].x[63:0];
            in_ch.x_mid  <= op_queue[0].x[127:64];
            in_ch.x_high <= op_queue[0].x[OPER_W-1:128];
            in_ch.y_low  <= op_queue[0].y[63:0];
            in_ch.y_mid  <= op_queue[0].y[127:64];
            in_ch.y_high <= op_queue[0].y[OPER_W-1:128];
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (snk_gap > 0) begin
        snk_gap = snk_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (op_queue.size() > 150 && $urandom_range(0, 6) == 0) begin
        snk_gap = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: predicts accepted items and checks results on rising edge
  always @(posedge clk) begin
    field_op_t         op;
    logic [OPER_W-1:0] got;
    logic [OPER_W-1:0] want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        op.func = func_t'(in_ch.func);
        op.x = {in_ch.x_high, in_ch.x_mid, in_ch.x_low};
        op.y = {in_ch.y_high, in_ch.y_mid, in_ch.y_low};
        z_queue = {z_queue, field_result(op)};
        accepted = 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.z_high, out_ch.z_mid, out_ch.z_low};
        if (z_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item z=%h", got);
        end else begin
          want = z_queue.pop_front();
          if (got[63:0] !== want[63:0] || got[127:64] !== want[127:64]
              || got[OPER_W-1:128] !== want[OPER_W-1:128]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %h got %h", want, got);
          end
        end
      end
    end
  end

  initial begin
    logic [OPER_W-1:0] pm1;
    logic [OPER_W-1:0] ones;
    int                f;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_ADD;
    in_ch.x_low = '0;
    in_ch.x_mid = '0;
    in_ch.x_high = '0;
    in_ch.y_low = '0;
    in_ch.y_mid = '0;
    in_ch.y_high = '0;
    out_ch.ready = 1'b0;
    pm1 = PRIME[OPER_W-1:0] - 1'b1;
    ones = '1;

    // edge cases: zero, p-1, p, all ones, negation, wrap, unused code
    queue_op(FUNC_ADD, '0, '0);
    queue_op(FUNC_ADD, pm1, OPER_W'(1));
    queue_op(FUNC_ADD, pm1, pm1);
    queue_op(FUNC_ADD, ones, ones);
    queue_op(FUNC_SUB, '0, OPER_W'(1));
    queue_op(FUNC_SUB, '0, pm1);
    queue_op(FUNC_SUB, pm1, pm1);
    queue_op(FUNC_SUB, '0, ones);
    queue_op(FUNC_SUB, ones, '0);
    queue_op(FUNC_MUL, '0, pm1);
    queue_op(FUNC_MUL, OPER_W'(1), OPER_W'(1));
    queue_op(FUNC_MUL, pm1, pm1);
    queue_op(FUNC_MUL, ones, ones);
    queue_op(FUNC_MUL, PRIME[OPER_W-1:0], pm1);
    queue_op(FUNC_ADD, PRIME[OPER_W-1:0], '0);
    queue_op(FUNC_NOP, ones, ones);
    queue_op(FUNC_NOP, '0, '0);
    for (int i = 0; i < 1700; i++) begin
      f = $urandom_range(0, 15);
      queue_op(f == 15 ? FUNC_NOP : func_t'(f % 3), rand_operand(), rand_operand());
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || in_ch.valid) @(posedge clk);
    while (z_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && z_queue.size() == 0) begin
      $display("montgomery_prime_field_alu: match");
    end else begin
      $display("montgomery_prime_field_alu: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("montgomery_prime_field_alu: mismatch");
    $finish;
  end

endmodule
